@@ src/vdts_pkg.sv @@
// Package for the voxel distance trilinear sampler.
// Holds the payload structs, the queue entry type and the fixed-point constants.
// No dependencies.
package vdts_pkg;

  // Grid and number formats.
  localparam int MaxDim   = 64;
  localparam int DimW     = 6;
  localparam int FracBits = 16;
  localparam int PointW   = 20;
  localparam int VoxW     = 24;
  localparam int GridW    = 7;
  localparam int CutW     = 24;
  localparam int OutW     = 32;
  localparam int ScaledW  = PointW + 8;
  localparam int IdxW     = ScaledW - FracBits;
  localparam int WgtW     = FracBits + 1;
  localparam int PenW     = 32;
  localparam int BankAw   = 3 * (DimW - 1);
  localparam int NumBanks = 8;
  localparam int EpsFx    = ((1 << FracBits) + 500) / 1000;
  localparam logic [VoxW-1:0] VoxMax = {VoxW{1'b1}};

  // Configuration register indexes.
  localparam logic CfgGridSize = 1'b0;
  localparam logic CfgCutoff   = 1'b1;

  // Request modes.
  localparam logic ModeWrite = 1'b0;
  localparam logic ModeQuery = 1'b1;

  typedef enum logic [1:0] {
    OpWrite   = 2'd0,
    OpBlend   = 2'd1,
    OpOutside = 2'd2
  } op_e;

  typedef struct packed {
    logic                     mode;
    logic signed [PointW-1:0] point_x;
    logic signed [PointW-1:0] point_y;
    logic signed [PointW-1:0] point_z;
    logic [DimW-1:0]          cell_x;
    logic [DimW-1:0]          cell_y;
    logic [DimW-1:0]          cell_z;
    logic [VoxW-1:0]          cell_value;
  } in_item_t;

  typedef struct packed {
    logic [OutW-1:0] sampled_distance;
    logic            was_outside;
  } out_item_t;

  // One classified request as it waits between the front and the back.
  typedef struct packed {
    op_e                    op;
    logic [DimW-1:0]        base_x;
    logic [DimW-1:0]        base_y;
    logic [DimW-1:0]        base_z;
    logic [VoxW-1:0]        value;
    logic signed [WgtW-1:0] w_x;
    logic signed [WgtW-1:0] w_y;
    logic signed [WgtW-1:0] w_z;
    logic [PenW-1:0]        penalty;
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

@@ src/vdts_front.sv @@
// Front end of the sampler: accepts requests, scales query points by the grid
// size and classifies each one as write, blend or outside. Uses vdts_pkg.
module vdts_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  vdts_pkg::in_item_t         in_item_i,
  input  logic [vdts_pkg::GridW-1:0] grid_size_i,
  input  logic                       clear_busy_i,
  input  logic                       q_full_i,
  output logic                       push_o,
  output vdts_pkg::q_entry_t         entry_o
);
  import vdts_pkg::*;

  logic                      adv;
  logic [GridW-1:0]          n;
  logic signed [PointW-1:0]  pt [3];
  logic signed [ScaledW-1:0] s_d [3];
  logic signed [ScaledW-1:0] s_q [3];
  logic                      f1_valid_q;
  in_item_t                  f1_item_q;

  // Effective grid size is clamped to the store dimension.
  assign n = (grid_size_i > GridW'(MaxDim)) ? GridW'(MaxDim) : grid_size_i;

  assign pt[0] = in_item_i.point_x;
  assign pt[1] = in_item_i.point_y;
  assign pt[2] = in_item_i.point_z;

  // Scale each axis by the grid size.
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      s_d[a] = ScaledW'(pt[a] * $signed({1'b0, n}));
    end
  end

  // The stage moves whenever its result can go into the queue.
  assign adv        = !f1_valid_q || !q_full_i;
  assign in_stall_o = !adv || clear_busy_i;
  assign push_o     = f1_valid_q && !q_full_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_valid_q <= 1'b0;
    end else if (adv) begin
      f1_valid_q <= in_valid_i && !clear_busy_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      f1_item_q <= in_item_i;
      for (int a = 0; a < 3; a++) begin
        s_q[a] <= s_d[a];
      end
    end
  end

  // Classify: cell index by truncation toward zero, weight, outside penalty.
  always_comb begin
    logic signed [ScaledW-1:0] neg;
    logic signed [ScaledW-1:0] w_full;
    logic signed [IdxW-1:0]    idx [3];
    logic signed [WgtW-1:0]    w [3];
    logic signed [IdxW-1:0]    n_s;
    logic signed [IdxW-1:0]    nm1;
    logic signed [PenW-1:0]    limit;
    logic signed [PenW-1:0]    pen;
    logic                      outside;

    n_s     = $signed(IdxW'(n));
    nm1     = n_s - IdxW'(1);
    limit   = (PenW'(nm1) <<< FracBits) - PenW'(EpsFx);
    pen     = '0;
    outside = 1'b0;
    for (int a = 0; a < 3; a++) begin
      neg    = -s_q[a];
      idx[a] = s_q[a][ScaledW-1] ? -$signed({1'b0, neg[ScaledW-2:FracBits]})
                                 :  $signed({1'b0, s_q[a][ScaledW-2:FracBits]});
      w_full = s_q[a] - (ScaledW'(idx[a]) <<< FracBits);
      w[a]   = w_full[WgtW-1:0];
      if (idx[a][IdxW-1] || idx[a] >= nm1) begin
        outside = 1'b1;
      end
      if (idx[a][IdxW-1]) begin
        pen = pen - PenW'(s_q[a]);
      end else if (idx[a] >= n_s) begin
        pen = pen + PenW'(s_q[a]) - limit;
      end
    end

    entry_o.value   = f1_item_q.cell_value;
    entry_o.w_x     = w[0];
    entry_o.w_y     = w[1];
    entry_o.w_z     = w[2];
    entry_o.penalty = pen;
    if (f1_item_q.mode == ModeWrite) begin
      entry_o.op     = OpWrite;
      entry_o.base_x = f1_item_q.cell_x;
      entry_o.base_y = f1_item_q.cell_y;
      entry_o.base_z = f1_item_q.cell_z;
    end else begin
      entry_o.op     = outside ? OpOutside : OpBlend;
      entry_o.base_x = idx[0][DimW-1:0];
      entry_o.base_y = idx[1][DimW-1:0];
      entry_o.base_z = idx[2][DimW-1:0];
    end
  end

endmodule

@@ src/vdts_fifo.sv @@
// Short request queue between the front and the back of the sampler.
// Uses vdts_pkg for the entry type.
module vdts_fifo #(
  parameter int Depth = 4
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_i,
  input  vdts_pkg::q_entry_t      wdata_i,
  input  logic                    pop_i,
  output vdts_pkg::q_entry_t      rdata_o,
  output vdts_pkg::q_status_t     status_o
);
  import vdts_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  q_entry_t        mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign status_o.full  = (count_q == CntW'(Depth));
  assign status_o.empty = (count_q == '0);
  assign rdata_o        = mem_q[rd_ptr_q];

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

@@ src/vdts_bank.sv @@
// One parity bank of the voxel store: one write and one registered read a cycle.
// Uses vdts_pkg for widths.
module vdts_bank (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [vdts_pkg::BankAw-1:0] waddr_i,
  input  logic [vdts_pkg::VoxW-1:0]   wdata_i,
  input  logic                        re_i,
  input  logic [vdts_pkg::BankAw-1:0] raddr_i,
  output logic [vdts_pkg::VoxW-1:0]   rdata_o
);
  import vdts_pkg::*;

  logic [VoxW-1:0] mem [1 << BankAw];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

@@ src/vdts_back.sv @@
// Back end of the sampler: clears and owns the eight voxel banks, performs
// writes, reads eight corners and runs the separable blend. Uses vdts_pkg, vdts_bank.
module vdts_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  vdts_pkg::q_entry_t        entry_i,
  input  logic                      empty_i,
  output logic                      pop_o,
  input  logic [vdts_pkg::CutW-1:0] cutoff_i,
  output logic                      clear_busy_o,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output vdts_pkg::out_item_t       out_item_o
);
  import vdts_pkg::*;

  localparam int ValW   = 32;
  localparam int ProdW  = ValW + 1 + WgtW;
  localparam int Stages = 7;

  typedef struct packed {
    logic                   valid;
    op_e                    op;
    logic                   px;
    logic                   py;
    logic                   pz;
    logic signed [WgtW-1:0] w_x;
    logic signed [WgtW-1:0] w_y;
    logic signed [WgtW-1:0] w_z;
    logic [PenW-1:0]        penalty;
  } meta_t;

  function automatic logic signed [ValW-1:0] rnd_shift(input logic signed [ProdW-1:0] p);
    logic signed [ProdW-1:0] t;
    t = (p + (ProdW'(1) <<< (FracBits - 1))) >>> FracBits;
    return t[ValW-1:0];
  endfunction

  function automatic logic signed [ProdW-1:0] lerp_mul(input logic signed [ValW-1:0] a,
                                                       input logic signed [ValW-1:0] b,
                                                       input logic signed [WgtW-1:0] w);
    logic signed [ValW:0] d;
    d = {b[ValW-1], b} - {a[ValW-1], a};
    return ProdW'(d * w);
  endfunction

  logic              adv;
  logic              clr_busy_q;
  logic [BankAw-1:0] clr_addr_q;
  logic [VoxW-1:0]   rd [NumBanks];
  logic [2:0]        wr_bank;
  logic [BankAw-1:0] wr_addr;
  meta_t             meta_d;
  meta_t             meta_q [Stages];
  logic              out_valid_q;
  out_item_t         out_item_q;

  logic signed [ProdW-1:0] prod1_q [4];
  logic signed [ValW-1:0]  a1_q [4];
  logic signed [ValW-1:0]  c_q [4];
  logic signed [ProdW-1:0] prod2_q [2];
  logic signed [ValW-1:0]  a2_q [2];
  logic signed [ValW-1:0]  e_q [2];
  logic signed [ProdW-1:0] prod3_q;
  logic signed [ValW-1:0]  a3_q;
  logic signed [ValW-1:0]  res_q;

  // The whole back pipeline moves unless a finished result is held up.
  assign adv          = !out_valid_q || !out_stall_i;
  assign pop_o        = adv && !empty_i && !clr_busy_q;
  assign clear_busy_o = clr_busy_q;

  // Clearing pass after reset: one row of all eight banks per cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_busy_q) begin
      clr_addr_q <= clr_addr_q + 1'b1;
      if (clr_addr_q == {BankAw{1'b1}}) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  // Write target: bank by index parity, address by the upper index bits.
  assign wr_bank = {entry_i.base_z[0], entry_i.base_y[0], entry_i.base_x[0]};
  assign wr_addr = {entry_i.base_z[DimW-1:1], entry_i.base_y[DimW-1:1],
                    entry_i.base_x[DimW-1:1]};

  // Banks: each one serves the corner whose index parity matches it.
  for (genvar b = 0; b < NumBanks; b++) begin : g_bank
    localparam logic Bx = 1'((b >> 0) & 1);
    localparam logic By = 1'((b >> 1) & 1);
    localparam logic Bz = 1'((b >> 2) & 1);
    logic [DimW-1:0]   cx, cy, cz;
    logic [BankAw-1:0] raddr;
    logic              we;
    logic [BankAw-1:0] waddr;
    logic [VoxW-1:0]   wdata;

    assign cx    = (entry_i.base_x[0] == Bx) ? entry_i.base_x : entry_i.base_x + 1'b1;
    assign cy    = (entry_i.base_y[0] == By) ? entry_i.base_y : entry_i.base_y + 1'b1;
    assign cz    = (entry_i.base_z[0] == Bz) ? entry_i.base_z : entry_i.base_z + 1'b1;
    assign raddr = {cz[DimW-1:1], cy[DimW-1:1], cx[DimW-1:1]};
    assign we    = clr_busy_q ||
                   (pop_o && entry_i.op == OpWrite && wr_bank == 3'(b));
    assign waddr = clr_busy_q ? clr_addr_q : wr_addr;
    assign wdata = clr_busy_q ? VoxMax : entry_i.value;

    vdts_bank u_bank (
      .clk_i   (clk_i),
      .we_i    (we),
      .waddr_i (waddr),
      .wdata_i (wdata),
      .re_i    (adv),
      .raddr_i (raddr),
      .rdata_o (rd[b])
    );
  end

  // Request side information that travels alongside the data.
  always_comb begin
    meta_d.valid   = pop_o;
    meta_d.op      = entry_i.op;
    meta_d.px      = entry_i.base_x[0];
    meta_d.py      = entry_i.base_y[0];
    meta_d.pz      = entry_i.base_z[0];
    meta_d.w_x     = entry_i.w_x;
    meta_d.w_y     = entry_i.w_y;
    meta_d.w_z     = entry_i.w_z;
    meta_d.penalty = entry_i.penalty;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Stages; i++) begin
        meta_q[i] <= '0;
      end
    end else if (adv) begin
      meta_q[0] <= meta_d;
      for (int i = 1; i < Stages; i++) begin
        meta_q[i] <= meta_q[i-1];
      end
    end
  end

  // Blend along x: route the corners out of the banks and multiply.
  always_ff @(posedge clk_i) begin
    logic [2:0]            bsel;
    logic signed [ValW-1:0] v [8];
    if (adv) begin
      for (int k = 0; k < 8; k++) begin
        bsel = 3'(k) ^ {meta_q[0].pz, meta_q[0].py, meta_q[0].px};
        v[k] = $signed(ValW'(rd[bsel]));
      end
      for (int j = 0; j < 4; j++) begin
        a1_q[j]    <= v[2*j];
        prod1_q[j] <= lerp_mul(v[2*j], v[2*j+1], meta_q[0].w_x);
      end
    end
  end

  // Remaining steps: round and add, multiply along y, round and add, multiply along z, round and add.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int j = 0; j < 4; j++) begin
        c_q[j] <= a1_q[j] + rnd_shift(prod1_q[j]);
      end
      for (int j = 0; j < 2; j++) begin
        a2_q[j]    <= c_q[2*j];
        prod2_q[j] <= lerp_mul(c_q[2*j], c_q[2*j+1], meta_q[2].w_y);
        e_q[j]     <= a2_q[j] + rnd_shift(prod2_q[j]);
      end
      a3_q    <= e_q[0];
      prod3_q <= lerp_mul(e_q[0], e_q[1], meta_q[4].w_z);
      res_q   <= a3_q + rnd_shift(prod3_q);
    end
  end

  // Output register: cutoff and clamp for blends, penalty for outside points.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= meta_q[6].valid && (meta_q[6].op != OpWrite);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (meta_q[6].op == OpOutside) begin
        out_item_q.sampled_distance <= meta_q[6].penalty;
        out_item_q.was_outside      <= 1'b1;
      end else begin
        if (res_q[ValW-1] || res_q > $signed(ValW'(cutoff_i))) begin
          out_item_q.sampled_distance <= '0;
        end else begin
          out_item_q.sampled_distance <= OutW'(res_q);
        end
        out_item_q.was_outside <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

@@ src/voxel_distance_trilinear_sampler.sv @@
// Top level of the voxel distance trilinear sampler.
// Uses vdts_pkg, vdts_front, vdts_fifo and vdts_back.

// The sampler takes one request per clock unless it stalls its input: a voxel
// write or a point query. After reset it clears its eight parity banks to the
// maximum distance (one row of every bank per cycle) and stalls its input
// meanwhile; configuration writes are taken at any time. After that a request
// is taken every cycle while the queue has room, since the eight corners of a
// cell lie in eight different banks, each with its own read port. A query
// result passes the front register, which loads at the accepting edge, then
// the queue, the bank read, six blend stages and the output register. Writes
// give no result. A queue of QUEUE_DEPTH requests lets the front keep
// accepting while the output is held.
module voxel_distance_trilinear_sampler #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic                      cfg_idx_i,
  input  logic [vdts_pkg::CutW-1:0] cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  vdts_pkg::in_item_t        in_item_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output vdts_pkg::out_item_t       out_item_o
);
  import vdts_pkg::*;

  logic [GridW-1:0] grid_size_q;
  logic [CutW-1:0]  cutoff_q;
  logic             push, pop, clear_busy;
  q_entry_t         push_entry, pop_entry;
  q_status_t        q_status;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_size_q <= GridW'(64);
      cutoff_q    <= CutW'(13107);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgGridSize: grid_size_q <= cfg_wdata_i[GridW-1:0];
        CfgCutoff:   cutoff_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  vdts_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_item_i    (in_item_i),
    .grid_size_i  (grid_size_q),
    .clear_busy_i (clear_busy),
    .q_full_i     (q_status.full),
    .push_o       (push),
    .entry_o      (push_entry)
  );

  vdts_fifo #(
    .Depth (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .wdata_i  (push_entry),
    .pop_i    (pop),
    .rdata_o  (pop_entry),
    .status_o (q_status)
  );

  vdts_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .entry_i      (pop_entry),
    .empty_i      (q_status.empty),
    .pop_o        (pop),
    .cutoff_i     (cutoff_q),
    .clear_busy_o (clear_busy),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_item_o   (out_item_o)
  );

  // No request enters while the banks are being cleared.
  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clear_busy |-> in_stall_o)
    else $error("request accepted during clearing pass");

  // The queue is never pushed when full nor popped when empty.
  a_queue_safe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push && q_status.full) && !(pop && q_status.empty))
    else $error("queue overflow or underflow");

  // A blended result never exceeds the cutoff.
  a_blend_cutoff: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_item_o.was_outside) |->
      (out_item_o.sampled_distance <= OutW'(cutoff_q)))
    else $error("blend above cutoff");

endmodule
